// ===== rtl/core/ppc_pkg.sv =====
// shared types, constants and the microprogram of the positional pid block
// used by every module under rtl/core; depends on nothing
package ppc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GAIN_FRAC_DEF    = 8;
  localparam int GAIN_W           = 16;
  localparam int LIMIT_W          = 16;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int DRIVE_W          = 17;
  localparam int DRIVE_TDATA_W    = ((DRIVE_W + 7) / 8) * 8;
  localparam int SUM_W            = 32;
  localparam int STEP_W           = 4;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd4;

  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_DIV   = 4'd6;
  localparam logic [STEP_W-1:0] S_ADD_I = 4'd8;
  localparam logic [STEP_W-1:0] S_WAIT  = 4'd10;

  typedef enum logic [3:0] {
    OP_CAPTURE,
    OP_SUM,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ICHECK,
    OP_DIV,
    OP_REWIND,
    OP_ADD_I,
    OP_OCLAMP,
    OP_WAIT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_NO_INPUT,
    C_NO_CLAMP,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic iclamp;
    logic div_busy;
    logic out_full;
  } status_t;

  typedef struct packed {
    logic iclamp;
    logic div_busy;
  } dp_flags_t;

  // microprogram rom
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    begin
      unique case (step)
        4'd0:    w = '{OP_CAPTURE, C_NO_INPUT, S_IDLE};
        4'd1:    w = '{OP_SUM,     C_NEXT,     S_IDLE};
        4'd2:    w = '{OP_MUL_P,   C_NEXT,     S_IDLE};
        4'd3:    w = '{OP_MUL_I,   C_NEXT,     S_IDLE};
        4'd4:    w = '{OP_MUL_D,   C_NEXT,     S_IDLE};
        4'd5:    w = '{OP_ICHECK,  C_NO_CLAMP, S_ADD_I};
        4'd6:    w = '{OP_DIV,     C_DIV_BUSY, S_DIV};
        4'd7:    w = '{OP_REWIND,  C_NEXT,     S_IDLE};
        4'd8:    w = '{OP_ADD_I,   C_NEXT,     S_IDLE};
        4'd9:    w = '{OP_OCLAMP,  C_NEXT,     S_IDLE};
        4'd10:   w = '{OP_WAIT,    C_OUT_FULL, S_WAIT};
        4'd11:   w = '{OP_EMIT,    C_GOTO,     S_IDLE};
        default: w = '{OP_WAIT,    C_GOTO,     S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

// ===== rtl/core/ppc_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
// depends on ppc_pkg
module ppc_seq (
  input  logic             clk,
  input  logic             rst,
  input  ppc_pkg::status_t status,
  output ppc_pkg::uword_t  uword
);

  logic [ppc_pkg::STEP_W-1:0] step;
  logic [ppc_pkg::STEP_W-1:0] step_next;
  logic                       jump;

  assign uword = ppc_pkg::ucode(step);

  always_comb begin
    unique case (uword.cond)
      ppc_pkg::C_NEXT:     jump = 1'b0;
      ppc_pkg::C_GOTO:     jump = 1'b1;
      ppc_pkg::C_NO_INPUT: jump = !status.in_valid;
      ppc_pkg::C_NO_CLAMP: jump = !status.iclamp;
      ppc_pkg::C_DIV_BUSY: jump = status.div_busy;
      ppc_pkg::C_OUT_FULL: jump = status.out_full;
      default:             jump = 1'b0;
    endcase
    step_next = jump ? uword.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ppc_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/core/ppc_dp.sv =====
// pid datapath: error, saturating sum, shared multiplier, accumulator,
// clamps and a radix-2 divider for the anti-windup sum rewrite; depends on ppc_pkg
module ppc_dp #(
  parameter int SAMPLE_WIDTH   = ppc_pkg::SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = ppc_pkg::GAIN_FRAC_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ppc_pkg::op_t                           op,
  input  logic                                   load,
  input  logic signed [SAMPLE_WIDTH-1:0]         target,
  input  logic signed [SAMPLE_WIDTH-1:0]         measured,
  input  logic signed [ppc_pkg::GAIN_W-1:0]      gain_p,
  input  logic signed [ppc_pkg::GAIN_W-1:0]      gain_i,
  input  logic signed [ppc_pkg::GAIN_W-1:0]      gain_d,
  input  logic        [ppc_pkg::LIMIT_W-1:0]     integral_limit,
  input  logic        [ppc_pkg::LIMIT_W-1:0]     output_limit,
  output logic signed [ppc_pkg::DRIVE_W-1:0]     drive,
  output logic                                   integral_clamped,
  output ppc_pkg::dp_flags_t                     flags
);

  localparam int ERR_W   = SAMPLE_WIDTH + 1;
  localparam int DIF_W   = SAMPLE_WIDTH + 2;
  localparam int MB_W    = (DIF_W > ppc_pkg::SUM_W) ? DIF_W : ppc_pkg::SUM_W;
  localparam int PROD_W  = ppc_pkg::GAIN_W + MB_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SA_W    = ((ERR_W > ppc_pkg::SUM_W) ? ERR_W : ppc_pkg::SUM_W) + 1;
  localparam int LIM_W   = ppc_pkg::LIMIT_W + GAIN_FRAC_BITS;
  localparam int CNT_W   = $clog2(LIM_W);
  localparam int DVS_W   = ppc_pkg::GAIN_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIM_W - 1);
  localparam logic signed [SA_W-1:0] SUM_MAX = SA_W'(64'sd2147483647);
  localparam logic signed [SA_W-1:0] SUM_MIN = SA_W'(-64'sd2147483648);
  localparam logic signed [ACC_W-1:0] RND = ACC_W'((64'sd1 <<< GAIN_FRAC_BITS) - 64'sd1);

  logic signed [ERR_W-1:0]         err;
  logic signed [ERR_W-1:0]         prev;
  logic signed [DIF_W-1:0]         diff;
  logic signed [ppc_pkg::SUM_W-1:0] sum;
  logic signed [PROD_W-1:0]        prod;
  logic signed [PROD_W-1:0]        iterm;
  logic signed [ACC_W-1:0]         acc;
  logic                            iclamp_r;
  logic                            neg_q;
  logic        [DVS_W-1:0]         dvs;
  logic        [DVS_W-1:0]         rem;
  logic        [LIM_W-1:0]         quo;
  logic        [CNT_W-1:0]         cnt;

  logic signed [ppc_pkg::GAIN_W-1:0] mul_a;
  logic signed [MB_W-1:0]          mul_b;
  logic signed [PROD_W-1:0]        mul_out;
  logic signed [SA_W-1:0]          sum_add;
  logic        [LIM_W-1:0]         ilim;
  logic signed [ACC_W-1:0]         olim;
  logic        [PROD_W-1:0]        iterm_mag;
  logic                            iclamp;
  logic        [DVS_W:0]           rem_sh;
  logic        [ppc_pkg::SUM_W:0]  q_ext;
  logic signed [ACC_W-1:0]         acc_rnd;
  logic signed [ACC_W-1:0]         acc_shr;

  always_comb begin
    unique case (op)
      ppc_pkg::OP_MUL_I: begin
        mul_a = gain_i;
        mul_b = MB_W'(sum);
      end
      ppc_pkg::OP_MUL_D: begin
        mul_a = gain_d;
        mul_b = MB_W'(diff);
      end
      default: begin
        mul_a = gain_p;
        mul_b = MB_W'(err);
      end
    endcase
  end

  assign mul_out   = mul_a * mul_b;
  assign sum_add   = SA_W'(sum) + SA_W'(err);
  assign ilim      = LIM_W'(integral_limit) << GAIN_FRAC_BITS;
  assign olim      = signed'(ACC_W'(LIM_W'(output_limit) << GAIN_FRAC_BITS));
  assign iterm_mag = iterm[PROD_W-1] ? PROD_W'(-iterm) : PROD_W'(iterm);
  assign iclamp    = iterm_mag > PROD_W'(ilim);
  assign rem_sh    = {rem, quo[LIM_W-1]};
  assign q_ext     = (ppc_pkg::SUM_W + 1)'(quo);

  // truncate toward zero
  assign acc_rnd = acc[ACC_W-1] ? acc + RND : acc;
  assign acc_shr = acc_rnd >>> GAIN_FRAC_BITS;
  assign drive   = acc_shr[ppc_pkg::DRIVE_W-1:0];

  assign integral_clamped = iclamp_r;
  assign flags.iclamp     = iclamp;
  assign flags.div_busy   = cnt != CNT_LAST;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      prev <= '0;
    end else begin
      unique case (op)
        ppc_pkg::OP_CAPTURE: begin
          if (load) begin
            err <= ERR_W'(target) - ERR_W'(measured);
          end
        end
        ppc_pkg::OP_SUM: begin
          if (sum_add > SUM_MAX) begin
            sum <= 32'sh7fffffff;
          end else if (sum_add < SUM_MIN) begin
            sum <= 32'sh80000000;
          end else begin
            sum <= ppc_pkg::SUM_W'(sum_add);
          end
          diff <= DIF_W'(err) - DIF_W'(prev);
          prev <= err;
        end
        ppc_pkg::OP_MUL_P: begin
          prod <= mul_out;
        end
        ppc_pkg::OP_MUL_I: begin
          acc  <= ACC_W'(prod);
          prod <= mul_out;
        end
        ppc_pkg::OP_MUL_D: begin
          iterm <= prod;
          prod  <= mul_out;
        end
        ppc_pkg::OP_ICHECK: begin
          acc      <= acc + ACC_W'(prod);
          iclamp_r <= iclamp;
          if (iclamp) begin
            iterm <= iterm[PROD_W-1] ? -signed'(PROD_W'(ilim)) : signed'(PROD_W'(ilim));
          end
          neg_q <= iterm[PROD_W-1] ^ gain_i[ppc_pkg::GAIN_W-1];
          dvs   <= gain_i[ppc_pkg::GAIN_W-1] ? DVS_W'(-gain_i) : DVS_W'(gain_i);
          rem   <= '0;
          quo   <= ilim;
          cnt   <= '0;
        end
        ppc_pkg::OP_DIV: begin
          if (rem_sh >= {1'b0, dvs}) begin
            rem <= DVS_W'(rem_sh - {1'b0, dvs});
            quo <= {quo[LIM_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[DVS_W-1:0];
            quo <= {quo[LIM_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        ppc_pkg::OP_REWIND: begin
          if (!neg_q) begin
            sum <= (q_ext > 33'h07fffffff) ? 32'sh7fffffff : signed'(ppc_pkg::SUM_W'(q_ext));
          end else begin
            sum <= (q_ext > 33'h080000000) ? 32'sh80000000
                                           : signed'(ppc_pkg::SUM_W'(33'd0 - q_ext));
          end
        end
        ppc_pkg::OP_ADD_I: begin
          acc <= acc + ACC_W'(iterm);
        end
        ppc_pkg::OP_OCLAMP: begin
          if (acc > olim) begin
            acc <= olim;
          end else if (acc < -olim) begin
            acc <= -olim;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/positional_pid_with_clamps.sv =====
// positional pid with integral anti-windup and output clamp, microcoded
// accepts one request at a time and takes the next only after emitting the result
// the pace is set by the 12-step microprogram, the wait on a full result register
// and, on a clamp, the one-bit-a-cycle divider (16 + GAIN_FRAC_BITS steps)
// rst (synchronous): gains 0, limits 65535, sum and last error 0, no result pending
// depends on ppc_pkg, ppc_seq, ppc_dp
module positional_pid_with_clamps #(
  parameter int SAMPLE_WIDTH   = ppc_pkg::SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = ppc_pkg::GAIN_FRAC_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // target, measured
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // drive
  output logic [ppc_pkg::DRIVE_TDATA_W-1:0]     m_axis_tdata,
  // integral_clamped
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_wr_en,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ppc_pkg::CFG_W-1:0]             cfg_data
);

  logic signed [ppc_pkg::GAIN_W-1:0]  gain_p;
  logic signed [ppc_pkg::GAIN_W-1:0]  gain_i;
  logic signed [ppc_pkg::GAIN_W-1:0]  gain_d;
  logic        [ppc_pkg::LIMIT_W-1:0] integral_limit;
  logic        [ppc_pkg::LIMIT_W-1:0] output_limit;

  ppc_pkg::uword_t    uword;
  ppc_pkg::status_t   status;
  ppc_pkg::dp_flags_t flags;
  logic signed [ppc_pkg::DRIVE_W-1:0] dp_drive;
  logic                               dp_clamped;
  logic                               in_accept;
  logic                               out_full;
  logic [ppc_pkg::DRIVE_W-1:0]        out_drive;
  logic                               out_clamped;

  assign s_axis_tready = uword.op == ppc_pkg::OP_CAPTURE;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign status.in_valid = s_axis_tvalid;
  assign status.iclamp   = flags.iclamp;
  assign status.div_busy = flags.div_busy;
  assign status.out_full = out_full;

  ppc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  ppc_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (uword.op),
    .load             (in_accept),
    .target           (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .measured         (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .gain_p           (gain_p),
    .gain_i           (gain_i),
    .gain_d           (gain_d),
    .integral_limit   (integral_limit),
    .output_limit     (output_limit),
    .drive            (dp_drive),
    .integral_clamped (dp_clamped),
    .flags            (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= '1;
      output_limit   <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ppc_pkg::REG_GAIN_P:    gain_p         <= cfg_data;
        ppc_pkg::REG_GAIN_I:    gain_i         <= cfg_data;
        ppc_pkg::REG_GAIN_D:    gain_d         <= cfg_data;
        ppc_pkg::REG_INT_LIMIT: integral_limit <= cfg_data;
        ppc_pkg::REG_OUT_LIMIT: output_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (uword.op == ppc_pkg::OP_EMIT) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uword.op == ppc_pkg::OP_EMIT) begin
      out_drive   <= dp_drive;
      out_clamped <= dp_clamped;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = ppc_pkg::DRIVE_TDATA_W'(out_drive);
  assign m_axis_tuser  = out_clamped;

endmodule

// ===== rtl/core/ppc_check.sv =====
// port-level checker for positional_pid_with_clamps and its bind statement
// depends on ppc_pkg
module ppc_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [ppc_pkg::DRIVE_TDATA_W-1:0]   m_axis_tdata
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before taken");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

  // no result straight after a request
  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // clamped drive stays within +/- 65535
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[ppc_pkg::DRIVE_W-1:0] != 17'h10000)
    else $error("drive out of range");

endmodule

bind positional_pid_with_clamps ppc_check u_ppc_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
